/* hdl/dwpi_pkg.sv */
// Shared types and constants of the dual wheel PI speed controller.
// Used by dwpi_mul, dwpi_div and dual_wheel_pi_speed_control_top; depends on nothing.
package dwpi_pkg;

   // Field and register widths.
   localparam int COUNTER_WIDTH      = 16;
   localparam int INTEGRAL_WIDTH_DEF = 32;
   localparam int TARGET_W           = 15;
   localparam int DIST_W             = 16;
   localparam int GAIN_W             = 32;
   localparam int PERIOD_W           = 16;
   localparam int DUTY_W             = 17;
   localparam int FRAC_W             = 16;
   localparam int FRAC_SHIFT         = 15;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   // Shared multiplier: a gain-wide operand by one 16-bit chunk.
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = GAIN_W + MUL_B_W;

   // Speed error: target minus three times (counter - rest).
   localparam int ERR_W      = ((COUNTER_WIDTH > TARGET_W) ? COUNTER_WIDTH : TARGET_W) + 4;
   localparam int REST_COUNT = 100;

   // PI term, each product limited in magnitude to 2^62.
   localparam int TERM_W         = 65;
   localparam int PROD_SAT_SHIFT = 62;
   localparam int SAT_MAG_W      = PROD_SAT_SHIFT + 1;

   // Fraction law per wheel, Q1.15.
   localparam longint BASE_LEFT  = 35389;
   localparam longint BASE_RIGHT = 37356;
   localparam longint MAX_LEFT   = 42074;
   localparam longint MAX_RIGHT  = 42598;
   localparam longint DIV_LEFT   = 25600;
   localparam longint DIV_RIGHT  = 256000;

   // Terms outside [lo, hi) clamp the fraction; inside, term + off is divided.
   localparam logic signed [TERM_W-1:0] CLAMP_LO_LEFT  = TERM_W'(-(BASE_LEFT * DIV_LEFT));
   localparam logic signed [TERM_W-1:0] CLAMP_LO_RIGHT = TERM_W'(-(BASE_RIGHT * DIV_RIGHT));
   localparam logic signed [TERM_W-1:0] CLAMP_HI_LEFT  =
      TERM_W'((MAX_LEFT + 1 - BASE_LEFT) * DIV_LEFT);
   localparam logic signed [TERM_W-1:0] CLAMP_HI_RIGHT =
      TERM_W'((MAX_RIGHT + 1 - BASE_RIGHT) * DIV_RIGHT);
   localparam logic signed [TERM_W-1:0] CLAMP_OFF_LEFT  = TERM_W'(BASE_LEFT * DIV_LEFT);
   localparam logic signed [TERM_W-1:0] CLAMP_OFF_RIGHT = TERM_W'(BASE_RIGHT * DIV_RIGHT);

   // Divider: dividend below (MAX_RIGHT + 1) * DIV_RIGHT fits 34 bits.
   // DIV_LEFT is 25 << 10 and DIV_RIGHT is 125 << 11. The shift removes the power of two,
   // and the odd factor goes by a reciprocal with 32 fraction bits, which is exact for
   // any 24-bit shifted dividend.
   localparam int DIVN_W      = 34;
   localparam int SHIFT_LEFT  = 10;
   localparam int SHIFT_RIGHT = 11;
   localparam int QUOT_Y_W    = DIVN_W - SHIFT_LEFT;
   localparam int RECIP_W     = 28;
   localparam int RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0] RECIP_LEFT  = RECIP_W'(171798692);
   localparam logic [RECIP_W-1:0] RECIP_RIGHT = RECIP_W'(34359739);

   // Wheel select codes.
   localparam logic WHEEL_LEFT  = 1'b0;
   localparam logic WHEEL_RIGHT = 1'b1;

   // Register reset values.
   localparam logic [TARGET_W-1:0] RST_TARGET_LEFT  = TARGET_W'(50);
   localparam logic [TARGET_W-1:0] RST_TARGET_RIGHT = TARGET_W'(50);
   localparam logic [DIST_W-1:0]   RST_STOP_DIST    = DIST_W'(13000);
   localparam logic [GAIN_W-1:0]   RST_PROP_GAIN    = GAIN_W'(16777);
   localparam logic [GAIN_W-1:0]   RST_INTEG_GAIN   = GAIN_W'(671089);
   localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD   = PERIOD_W'(65000);

   // Register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TARGET_LEFT  = 3'd0,
      CSR_TARGET_RIGHT = 3'd1,
      CSR_STOP_DIST    = 3'd2,
      CSR_PROP_GAIN    = 3'd3,
      CSR_INTEG_GAIN   = 3'd4,
      CSR_PWM_PERIOD   = 3'd5
   } dwpi_csr_type;

   typedef struct packed {
      logic [COUNTER_WIDTH-1:0] left_counter;
      logic [COUNTER_WIDTH-1:0] right_counter;
   } dwpi_req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_left;
      logic [DUTY_W-1:0] duty_right;
      logic              stopped;
   } dwpi_rsp_type;

   typedef struct packed {
      logic              start;
      logic              sel;
      logic [DIVN_W-1:0] dividend;
   } dwpi_div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quotient;
   } dwpi_div_rsp_type;

endpackage

/* hdl/dwpi_mul.sv */
// Shared 32 x 16 unsigned multiplier with a registered product.
// Depends on dwpi_pkg.
module dwpi_mul (
   input  logic                          clock,
   input  logic [dwpi_pkg::GAIN_W-1:0]   mul_a,
   input  logic [dwpi_pkg::MUL_B_W-1:0]  mul_b,
   output logic [dwpi_pkg::MUL_P_W-1:0]  mul_p
);
   import dwpi_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

/* hdl/dwpi_div.sv */
// Divider of a 34-bit dividend by the fixed per-wheel divisor: a shift and a
// reciprocal multiplication; dividend and product are registered. Depends on dwpi_pkg.
module dwpi_div (
   input  logic                               clock,
   input  logic                               reset,
   input  dwpi_pkg::dwpi_div_req_type         div_req,
   output dwpi_pkg::dwpi_div_rsp_type         div_rsp
);
   import dwpi_pkg::*;

   localparam int DPROD_W = QUOT_Y_W + RECIP_W;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [QUOT_Y_W-1:0] y_ff, y_in;
   logic [RECIP_W-1:0]  recip_ff, recip_in;
   logic [DPROD_W-1:0]  prod_ff, prod_in;

   always_comb begin
      busy_in  = div_req.start;
      done_in  = busy_ff;
      y_in     = y_ff;
      recip_in = recip_ff;
      if (div_req.start) begin
         if (div_req.sel == WHEEL_RIGHT) begin
            y_in     = QUOT_Y_W'(div_req.dividend >> SHIFT_RIGHT);
            recip_in = RECIP_RIGHT;
         end else begin
            y_in     = QUOT_Y_W'(div_req.dividend >> SHIFT_LEFT);
            recip_in = RECIP_LEFT;
         end
      end
   end

   assign prod_in = DPROD_W'(y_ff) * DPROD_W'(recip_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff     <= y_in;
      recip_ff <= recip_in;
      prod_ff  <= prod_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = prod_ff[RECIP_SHIFT +: FRAC_W];

endmodule

/* hdl/dual_wheel_pi_speed_control_top.sv */
// Dual wheel PI speed controller: registers, sequencer and result register.
// Uses dwpi_pkg, dwpi_mul and dwpi_div. Each product goes through the shared multiplier in
// NCHUNK 16-bit chunks; a clamped wheel skips the divider. The next request is taken in the
// cycle after the result is loaded. A stop request goes from the check state straight to the
// output state, and a request after a stop is taken and dropped without a result. Reset is
// synchronous and restores the configuration registers and the control state.
module dual_wheel_pi_speed_control_top #(
   parameter int INTEGRAL_WIDTH = dwpi_pkg::INTEGRAL_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dwpi_pkg::dwpi_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dwpi_pkg::dwpi_rsp_type             rsp_data,
   input  logic                               csr_we,
   input  logic [dwpi_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [dwpi_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dwpi_pkg::*;

   localparam int MAX_W   = (INTEGRAL_WIDTH > ERR_W) ? INTEGRAL_WIDTH : ERR_W;
   localparam int NCHUNK  = (MAX_W + MUL_B_W - 1) / MUL_B_W;
   localparam int CHUNK_W = $clog2(NCHUNK);
   localparam int MAG_W   = NCHUNK * MUL_B_W;
   localparam int PROD_W  = MAG_W + GAIN_W;
   localparam int SAT_W   = (PROD_W > SAT_MAG_W) ? PROD_W : SAT_MAG_W;
   localparam int SUM_W   = MAX_W + 1;
   localparam int DSUM_W  = COUNTER_WIDTH + 2;
   localparam int DCMP_W  = (COUNTER_WIDTH > DIST_W) ? COUNTER_WIDTH : DIST_W;
   localparam logic [SAT_W-1:0] PROD_LIMIT = SAT_W'(1) << PROD_SAT_SHIFT;

   localparam logic PROD_PROP  = 1'b0;
   localparam logic PROD_INTEG = 1'b1;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_CHECK = 11'b000_0000_0010,
      ST_ERROR = 11'b000_0000_0100,
      ST_MUL   = 11'b000_0000_1000,
      ST_ACC   = 11'b000_0001_0000,
      ST_SAT   = 11'b000_0010_0000,
      ST_CLAMP = 11'b000_0100_0000,
      ST_DIV   = 11'b000_1000_0000,
      ST_DUTY  = 11'b001_0000_0000,
      ST_DUTYW = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } dwpi_state_type;

   // Configuration registers.
   logic [TARGET_W-1:0] tgt_l_ff, tgt_r_ff;
   logic [DIST_W-1:0]   stop_dist_ff;
   logic [GAIN_W-1:0]   kp_ff, ki_ff;
   logic [PERIOD_W-1:0] period_ff;

   // Control state.
   dwpi_state_type                    state_ff, state_in;
   logic                              running_ff, running_in;
   logic [COUNTER_WIDTH-1:0]          dist_ff, dist_in;
   logic signed [INTEGRAL_WIDTH-1:0]  integ_l_ff, integ_l_in;
   logic signed [INTEGRAL_WIDTH-1:0]  integ_r_ff, integ_r_in;
   logic                              wheel_ff, wheel_in;
   logic                              prod_sel_ff, prod_sel_in;
   logic [CHUNK_W-1:0]                chunk_ff, chunk_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [COUNTER_WIDTH-1:0]  lc_ff, lc_in, rc_ff, rc_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [PROD_W-1:0]         acc_ff, acc_in;
   logic signed [TERM_W-1:0]  term_ff, term_in;
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic [DUTY_W-1:0]         duty_l_ff, duty_l_in, duty_r_ff, duty_r_in;
   logic                      stopped_ff, stopped_in;
   dwpi_rsp_type              rsp_data_ff, rsp_data_in;

   // Shared units.
   logic [GAIN_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_P_W-1:0]  mul_p;
   dwpi_div_req_type    div_req;
   dwpi_div_rsp_type    div_rsp;

   // Per-wheel arithmetic.
   logic [COUNTER_WIDTH-1:0]         cur_counter;
   logic [TARGET_W-1:0]              cur_target;
   logic signed [INTEGRAL_WIDTH-1:0] cur_integ;
   logic signed [ERR_W-1:0]          speed, err_val;
   logic [ERR_W-1:0]                 err_abs;
   logic signed [SUM_W-1:0]          integ_sum;
   logic [SUM_W-INTEGRAL_WIDTH:0]    integ_top;
   logic signed [INTEGRAL_WIDTH-1:0] integ_sat;
   logic [INTEGRAL_WIDTH-1:0]        integ_abs;
   logic signed [DSUM_W-1:0]         dsum;
   logic [COUNTER_WIDTH-1:0]         dist_next;
   logic [SAT_W-1:0]                 acc_ext, sat_val;
   logic [SAT_MAG_W-1:0]             sat_mag;
   logic signed [TERM_W-1:0]         term_add;
   logic signed [TERM_W-1:0]         clamp_lo, clamp_hi, clamp_off;
   logic                             stop_now;

   dwpi_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   dwpi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign cur_counter = (wheel_ff == WHEEL_RIGHT) ? rc_ff : lc_ff;
   assign cur_target  = (wheel_ff == WHEEL_RIGHT) ? tgt_r_ff : tgt_l_ff;
   assign cur_integ   = (wheel_ff == WHEEL_RIGHT) ? integ_r_ff : integ_l_ff;

   assign speed   = $signed(ERR_W'(cur_counter)) - $signed(ERR_W'(REST_COUNT));
   assign err_val = $signed(ERR_W'(cur_target)) - (speed + (speed <<< 1));
   assign err_abs = err_val[ERR_W-1] ? ERR_W'(-err_val) : ERR_W'(err_val);

   // The integrator saturates when the sum's upper bits are not all sign copies.
   assign integ_sum = SUM_W'(cur_integ) + SUM_W'(err_val);
   assign integ_top = integ_sum[SUM_W-1:INTEGRAL_WIDTH-1];
   always_comb begin
      if ((&integ_top) || !(|integ_top)) begin
         integ_sat = integ_sum[INTEGRAL_WIDTH-1:0];
      end else if (integ_sum[SUM_W-1]) begin
         integ_sat = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
      end else begin
         integ_sat = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
      end
   end
   assign integ_abs = cur_integ[INTEGRAL_WIDTH-1] ? INTEGRAL_WIDTH'(-cur_integ)
                                                  : INTEGRAL_WIDTH'(cur_integ);

   // Distance sum saturates at zero and at the counter's full scale.
   assign dsum = $signed(DSUM_W'(dist_ff)) + $signed(DSUM_W'(req_data.left_counter))
                 - $signed(DSUM_W'(REST_COUNT));
   always_comb begin
      if (dsum[DSUM_W-1]) begin
         dist_next = '0;
      end else if (dsum[COUNTER_WIDTH]) begin
         dist_next = '1;
      end else begin
         dist_next = dsum[COUNTER_WIDTH-1:0];
      end
   end

   assign stop_now = (tgt_l_ff == '0) || (tgt_r_ff == '0) ||
                     (DCMP_W'(dist_ff) >= DCMP_W'(stop_dist_ff));

   assign acc_ext  = SAT_W'(acc_ff);
   assign sat_val  = (acc_ext > PROD_LIMIT) ? PROD_LIMIT : acc_ext;
   assign sat_mag  = sat_val[SAT_MAG_W-1:0];
   assign term_add = neg_ff ? -$signed(TERM_W'(sat_mag)) : $signed(TERM_W'(sat_mag));

   assign clamp_lo  = (wheel_ff == WHEEL_RIGHT) ? CLAMP_LO_RIGHT : CLAMP_LO_LEFT;
   assign clamp_hi  = (wheel_ff == WHEEL_RIGHT) ? CLAMP_HI_RIGHT : CLAMP_HI_LEFT;
   assign clamp_off = (wheel_ff == WHEEL_RIGHT) ? CLAMP_OFF_RIGHT : CLAMP_OFF_LEFT;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         mul_a = (prod_sel_ff == PROD_INTEG) ? ki_ff : kp_ff;
         mul_b = mag_ff[MAG_W-1 -: MUL_B_W];
      end else if (state_ff == ST_DUTY) begin
         mul_a = GAIN_W'(period_ff);
         mul_b = frac_ff;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      dist_in      = dist_ff;
      integ_l_in   = integ_l_ff;
      integ_r_in   = integ_r_ff;
      wheel_in     = wheel_ff;
      prod_sel_in  = prod_sel_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      lc_in        = lc_ff;
      rc_in        = rc_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      term_in      = term_ff;
      frac_in      = frac_ff;
      duty_l_in    = duty_l_ff;
      duty_r_in    = duty_r_ff;
      stopped_in   = stopped_ff;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            // After a stop, requests are taken and dropped without a result.
            if (req_valid && running_ff) begin
               lc_in    = req_data.left_counter;
               rc_in    = req_data.right_counter;
               dist_in  = dist_next;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stop_now) begin
               duty_l_in  = DUTY_W'(period_ff);
               duty_r_in  = DUTY_W'(period_ff);
               stopped_in = 1'b1;
               integ_l_in = '0;
               integ_r_in = '0;
               dist_in    = '0;
               running_in = 1'b0;
               state_in   = ST_OUT;
            end else begin
               stopped_in = 1'b0;
               wheel_in   = WHEEL_LEFT;
               state_in   = ST_ERROR;
            end
         end
         ST_ERROR: begin
            if (wheel_ff == WHEEL_RIGHT) begin
               integ_r_in = integ_sat;
            end else begin
               integ_l_in = integ_sat;
            end
            mag_in      = MAG_W'(err_abs);
            neg_in      = err_val[ERR_W-1];
            prod_sel_in = PROD_PROP;
            chunk_in    = CHUNK_W'(NCHUNK - 1);
            acc_in      = '0;
            term_in     = '0;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            mag_in   = mag_ff << MUL_B_W;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // Chunks arrive most significant first.
            acc_in = (acc_ff << MUL_B_W) + PROD_W'(mul_p);
            if (chunk_ff == '0) begin
               state_in = ST_SAT;
            end else begin
               chunk_in = chunk_ff - CHUNK_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_SAT: begin
            term_in = term_ff + term_add;
            if (prod_sel_ff == PROD_PROP) begin
               prod_sel_in = PROD_INTEG;
               mag_in      = MAG_W'(integ_abs);
               neg_in      = cur_integ[INTEGRAL_WIDTH-1];
               chunk_in    = CHUNK_W'(NCHUNK - 1);
               acc_in      = '0;
               state_in    = ST_MUL;
            end else begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (term_ff < clamp_lo) begin
               frac_in  = '0;
               state_in = ST_DUTY;
            end else if (term_ff >= clamp_hi) begin
               frac_in  = (wheel_ff == WHEEL_RIGHT) ? FRAC_W'(MAX_RIGHT) : FRAC_W'(MAX_LEFT);
               state_in = ST_DUTY;
            end else begin
               div_req.start    = 1'b1;
               div_req.sel      = wheel_ff;
               div_req.dividend = DIVN_W'(term_ff + clamp_off);
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               frac_in  = div_rsp.quotient;
               state_in = ST_DUTY;
            end
         end
         ST_DUTY: begin
            state_in = ST_DUTYW;
         end
         ST_DUTYW: begin
            if (wheel_ff == WHEEL_RIGHT) begin
               duty_r_in = mul_p[FRAC_SHIFT +: DUTY_W];
               state_in  = ST_OUT;
            end else begin
               duty_l_in = mul_p[FRAC_SHIFT +: DUTY_W];
               wheel_in  = WHEEL_RIGHT;
               state_in  = ST_ERROR;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.duty_left  = duty_l_ff;
               rsp_data_in.duty_right = duty_r_ff;
               rsp_data_in.stopped    = stopped_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b1;
         dist_ff      <= '0;
         integ_l_ff   <= '0;
         integ_r_ff   <= '0;
         wheel_ff     <= WHEEL_LEFT;
         prod_sel_ff  <= PROD_PROP;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         dist_ff      <= dist_in;
         integ_l_ff   <= integ_l_in;
         integ_r_ff   <= integ_r_in;
         wheel_ff     <= wheel_in;
         prod_sel_ff  <= prod_sel_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lc_ff       <= lc_in;
      rc_ff       <= rc_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      term_ff     <= term_in;
      frac_ff     <= frac_in;
      duty_l_ff   <= duty_l_in;
      duty_r_ff   <= duty_r_in;
      stopped_ff  <= stopped_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration writes; an index past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_l_ff     <= RST_TARGET_LEFT;
         tgt_r_ff     <= RST_TARGET_RIGHT;
         stop_dist_ff <= RST_STOP_DIST;
         kp_ff        <= RST_PROP_GAIN;
         ki_ff        <= RST_INTEG_GAIN;
         period_ff    <= RST_PWM_PERIOD;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TARGET_LEFT:  tgt_l_ff     <= csr_wdata[TARGET_W-1:0];
            CSR_TARGET_RIGHT: tgt_r_ff     <= csr_wdata[TARGET_W-1:0];
            CSR_STOP_DIST:    stop_dist_ff <= csr_wdata[DIST_W-1:0];
            CSR_PROP_GAIN:    kp_ff        <= csr_wdata[GAIN_W-1:0];
            CSR_INTEG_GAIN:   ki_ff        <= csr_wdata[GAIN_W-1:0];
            CSR_PWM_PERIOD:   period_ff    <= csr_wdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Once stopped, the integrators and the distance sum stay cleared.
   a_stopped_clear: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (dist_ff == '0 && integ_l_ff == '0 && integ_r_ff == '0))
      else $error("state not cleared after stop");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside its wait state");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUTY && wheel_ff == WHEEL_LEFT) |-> (frac_ff <= FRAC_W'(MAX_LEFT)))
      else $error("left fraction above its limit");

   a_stop_duty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && stopped_ff) |->
         (duty_l_ff == DUTY_W'(period_ff) && duty_r_ff == DUTY_W'(period_ff)))
      else $error("stop result without neutral duty");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

endmodule
